// File: hdl/bs_pkg.sv
// Shared types and constants for the bubble sorter.
`timescale 1ns / 1ps
package bs_pkg;

  localparam int unsigned DATA_W = 32;

  typedef logic signed [DATA_W-1:0] elem_t;

  // Outcome of one compare-exchange: lower value goes left, higher carries on.
  typedef struct packed {
    elem_t lo;
    elem_t hi;
  } cmp_res_t;

endpackage

// File: hdl/bs_cmp_swap.sv
// Compare-exchange unit shared by every step of every sort pass.
`timescale 1ns / 1ps
module bs_cmp_swap (
  input  bs_pkg::elem_t    left_i,
  input  bs_pkg::elem_t    right_i,
  output bs_pkg::cmp_res_t res_o
);
  import bs_pkg::*;

  logic greater;

  // Exchange only on a strictly greater left value, so equal values keep order.
  assign greater  = left_i > right_i;
  assign res_o.lo = greater ? right_i : left_i;
  assign res_o.hi = greater ? left_i : right_i;

endmodule

// File: hdl/bubble_sorter.sv
// Top level of the bubble sorter: element store, pass sequencer and output register.
//
// Usage: values arrive on the input channel (value_i, final_item_i) one item per
// cycle while in_ready_o is high. The first DEPTH values of a set are kept; later
// ones are dropped and mark the set as overflowed. The item with final_item_i set
// closes the set. The block then drops in_ready_o, sorts the kept values with a
// single compare-exchange unit and a one-read, one-write element memory, and sends
// them smallest first on the output channel, last_result_o set on the final one
// and overflow_o set on all of them if anything was dropped.
// Sorting: each bubble pass over elements 0..t has one memory read lead-in, t
// compare steps and one write-back of the carried maximum. Each result is then
// read from the memory and loaded into the output register; a stalled result
// holds in the output register until taken.
// Reset clears the element count, the overflow flag and all valid/state bits; the
// memory contents are not cleared and need not be. in_ready_o returns high in the
// cycle after the last result of a set is taken.
`timescale 1ns / 1ps
module bubble_sorter #(
  parameter int unsigned DEPTH = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  bs_pkg::elem_t value_i,
  input  logic          final_item_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output bs_pkg::elem_t sorted_value_o,
  output logic          last_result_o,
  output logic          overflow_o
);
  import bs_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_FIRST = 3'd1;
  localparam logic [2:0] S_CMP   = 3'd2;
  localparam logic [2:0] S_END   = 3'd3;
  localparam logic [2:0] S_EMRD  = 3'd4;
  localparam logic [2:0] S_LOAD  = 3'd5;
  localparam logic [2:0] S_HOLD  = 3'd6;

  logic [2:0]    state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          drop_q, drop_d;
  logic [AW-1:0] top_q, top_d;
  logic [AW-1:0] k_q, k_d;
  elem_t         carry_q, carry_d;
  logic          out_valid_q, out_valid_d;
  elem_t         out_val_q;
  logic          out_last_q, out_ovf_q;
  logic          out_load;

  // element memory: one write port, one registered read port
  elem_t         mem [DEPTH];
  elem_t         rdata_q;
  logic          we;
  logic [AW-1:0] waddr, raddr;
  elem_t         wdata;

  logic          in_acc, out_acc, full, emit_last;
  logic [CW-1:0] n_set;
  cmp_res_t      cmp_res;

  bs_cmp_swap u_cmp (
    .left_i  (carry_q),
    .right_i (rdata_q),
    .res_o   (cmp_res)
  );

  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign out_acc    = out_valid_q && out_ready_i;
  assign full       = (cnt_q == CW'(DEPTH));
  assign n_set      = full ? cnt_q : cnt_q + CW'(1);
  assign emit_last  = ((CW'(k_q) + CW'(1)) == cnt_q);

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    drop_d      = drop_q;
    top_d       = top_q;
    k_d         = k_q;
    carry_d     = carry_q;
    out_valid_d = out_valid_q;
    out_load    = 1'b0;
    we          = 1'b0;
    waddr       = k_q;
    wdata       = value_i;
    raddr       = '0;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          we     = !full;
          waddr  = cnt_q[AW-1:0];
          wdata  = value_i;
          drop_d = drop_q | full;
          if (!final_item_i) begin
            cnt_d = n_set;
          end else begin
            cnt_d = n_set;
            k_d   = '0;
            top_d = AW'(n_set - CW'(1));
            // the store write, if any, lands at n-1 >= 1 here, so reading entry 0 is safe
            if (n_set > CW'(1)) begin
              state_d = S_FIRST;
            end else begin
              state_d = S_EMRD;
            end
          end
        end
      end
      S_FIRST: begin
        carry_d = rdata_q;
        raddr   = AW'(1);
        k_d     = AW'(1);
        state_d = S_CMP;
      end
      S_CMP: begin
        we      = 1'b1;
        waddr   = k_q - AW'(1);
        wdata   = cmp_res.lo;
        carry_d = cmp_res.hi;
        if (k_q == top_q) begin
          state_d = S_END;
        end else begin
          raddr = k_q + AW'(1);
          k_d   = k_q + AW'(1);
        end
      end
      S_END: begin
        // pass maximum settles at the top of this pass
        we    = 1'b1;
        waddr = top_q;
        wdata = carry_q;
        k_d   = '0;
        if (top_q == AW'(1)) begin
          state_d = S_EMRD;
        end else begin
          top_d   = top_q - AW'(1);
          state_d = S_FIRST;
        end
      end
      S_EMRD: begin
        raddr   = k_q;
        state_d = S_LOAD;
      end
      S_LOAD: begin
        out_load    = 1'b1;
        out_valid_d = 1'b1;
        state_d     = S_HOLD;
      end
      S_HOLD: begin
        if (out_acc) begin
          out_valid_d = 1'b0;
          if (emit_last) begin
            cnt_d   = '0;
            drop_d  = 1'b0;
            state_d = S_IDLE;
          end else begin
            raddr   = k_q + AW'(1);
            k_d     = k_q + AW'(1);
            state_d = S_LOAD;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      drop_q      <= 1'b0;
      top_q       <= '0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      drop_q      <= drop_d;
      top_q       <= top_d;
      k_q         <= k_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    carry_q <= carry_d;
    if (out_load) begin
      out_val_q  <= rdata_q;
      out_last_q <= emit_last;
      out_ovf_q  <= drop_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_q <= mem[raddr];
  end

  assign out_valid_o    = out_valid_q;
  assign sorted_value_o = out_val_q;
  assign last_result_o  = out_last_q;
  assign overflow_o     = out_ovf_q;

endmodule

// File: tb/sv/bubble_sorter_tb.sv
// Testbench for bubble_sorter: random sets of values checked against a sorting scoreboard.
`timescale 1ns / 1ps

class sort_scoreboard #(int unsigned DEPTH = 8);
  typedef struct {
    bs_pkg::elem_t value;
    logic          last;
    logic          ovf;
  } sorted_t;

  bs_pkg::elem_t kept[DEPTH];
  int unsigned   n_kept;
  bit            lost;
  sorted_t       sorted_q[$];
  int unsigned   errors;

  function new();
    n_kept = 0;
    lost   = 1'b0;
    errors = 0;
  endfunction

  // Accepted input item: keep it if there is room, sort and queue the set on the final one.
  function void note_item(bs_pkg::elem_t value, logic fin);
    bs_pkg::elem_t tmp;
    sorted_t       res;
    if (n_kept < DEPTH) begin
      kept[n_kept] = value;
      n_kept++;
    end else begin
      lost = 1'b1;
    end
    if (!fin) return;
    // only a strictly greater left neighbor moves, so equal values keep their order
    for (int top = int'(n_kept) - 1; top > 0; top--) begin
      for (int k = 0; k < top; k++) begin
        if (kept[k] > kept[k+1]) begin
          tmp       = kept[k];
          kept[k]   = kept[k+1];
          kept[k+1] = tmp;
        end
      end
    end
    for (int k = 0; k < int'(n_kept); k++) begin
      res.value = kept[k];
      res.last  = (k == int'(n_kept) - 1);
      res.ovf   = lost;
      sorted_q.push_back(res);
    end
    n_kept = 0;
    lost   = 1'b0;
  endfunction

  function void mismatch(string field, longint want, longint got);
    errors++;
    $display("%0t: %s mismatch: expected %0d, got %0d", $time, field, want, got);
  endfunction

  function void check_result(bs_pkg::elem_t value, logic last, logic ovf);
    sorted_t want;
    if (sorted_q.size() == 0) begin
      errors++;
      $display("%0t: unexpected result: expected none, got %0d", $time, value);
      return;
    end
    want = sorted_q.pop_front();
    if (value !== want.value) mismatch("sorted_value", want.value, value);
    if (last !== want.last) mismatch("last_result", want.last, last);
    if (ovf !== want.ovf) mismatch("overflow", want.ovf, ovf);
  endfunction

  function int unsigned outstanding();
    return sorted_q.size();
  endfunction
endclass

module bubble_sorter_tb;
  import bs_pkg::*;

  localparam int unsigned DEPTH        = 8;
  localparam int unsigned RANDOM_ITEMS = 310;
  localparam int unsigned CALM_ITEMS   = 50;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam elem_t       MIN_V        = 32'sh8000_0000;
  localparam elem_t       MAX_V        = 32'sh7fff_ffff;

  logic  clk_i        = 1'b0;
  logic  rst_ni       = 1'b0;
  logic  in_valid_i   = 1'b0;
  logic  in_ready_o;
  elem_t value_i      = '0;
  logic  final_item_i = 1'b0;
  logic  out_valid_o;
  logic  out_ready_i  = 1'b0;
  elem_t sorted_value_o;
  logic  last_result_o;
  logic  overflow_o;

  sort_scoreboard #(DEPTH) sb;
  elem_t       set_q[$];
  bit          calm       = 1'b0;
  bit          gaps_on    = 1'b0;
  bit          stalls_on  = 1'b1;
  int unsigned stall_left = 0;
  int unsigned cycles     = 0;

  always #10 clk_i = ~clk_i;

  bubble_sorter #(.DEPTH(DEPTH)) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .value_i        (value_i),
    .final_item_i   (final_item_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .sorted_value_o (sorted_value_o),
    .last_result_o  (last_result_o),
    .overflow_o     (overflow_o)
  );

  // handshake monitor
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i)
        sb.check_result(sorted_value_o, last_result_o, overflow_o);
      if (in_valid_i && in_ready_o)
        sb.note_item(value_i, final_item_i);
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // receiver: random stall bursts, switched on and off in stretches
  always @(negedge clk_i) begin
    if ($urandom_range(0, 39) == 0) stalls_on <= ~stalls_on;
    if (stall_left != 0) begin
      out_ready_i <= 1'b0;
      stall_left  <= stall_left - 1;
    end else if (!calm && stalls_on && $urandom_range(0, 4) == 0) begin
      out_ready_i <= 1'b0;
      stall_left  <= $urandom_range(0, 11);
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  function automatic elem_t pick_value();
    case ($urandom_range(0, 9))
      0:       return MIN_V;
      1:       return MAX_V;
      2:       return $urandom_range(0, 1) ? elem_t'(0) : elem_t'(-1);
      3, 4:    return elem_t'(int'($urandom_range(0, 15)) - 8);  // small range, many ties
      default: return elem_t'($urandom());
    endcase
  endfunction

  task automatic send_item(elem_t value, logic fin);
    int unsigned gap;
    @(negedge clk_i);
    if (!calm && gaps_on && $urandom_range(0, 3) == 0) begin
      gap        = $urandom_range(1, 12);
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    value_i      = value;
    final_item_i = fin;
    in_valid_i   = 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // sends the values in set_q as one set, final flag on the last
  task automatic send_set();
    gaps_on = ($urandom_range(0, 2) != 0);
    foreach (set_q[k]) send_item(set_q[k], k == set_q.size() - 1);
  endtask

  initial begin
    int unsigned sent;
    int unsigned len;
    sb   = new();
    sent = 0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // single-item sets at both extremes
    set_q = '{MIN_V};
    send_set();
    set_q = '{MAX_V};
    send_set();
    // exactly full store, extremes and ties
    set_q = '{MAX_V, 0, MIN_V, -1, 1, MAX_V, MIN_V + 1, -2};
    send_set();
    // equal values
    set_q = '{5, 5, -5, 5, -5};
    send_set();
    // store full when the final item arrives: it is dropped and the set overflows
    set_q = '{7, 6, 5, 4, 3, 2, 1, 0, MIN_V};
    send_set();

    while (sent < RANDOM_ITEMS) begin
      if (sent + CALM_ITEMS >= RANDOM_ITEMS) calm = 1'b1;
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(DEPTH + 1, DEPTH + 5)
                                        : $urandom_range(1, DEPTH);
      set_q.delete();
      repeat (len) set_q.push_back(pick_value());
      send_set();
      sent += len;
    end

    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.errors == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
